/* src/lattice_value_noise_3d_core_assert.svh */
// Assertion macros for the lattice value noise core.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef LATTICE_VALUE_NOISE_3D_CORE_ASSERT_SVH
`define LATTICE_VALUE_NOISE_3D_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LVN3_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LVN3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lvn3_pkg.sv */
// Shared constants and types for the lattice value noise core.
// No dependencies.
package lvn3_pkg;

  // fixed-point formats
  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W         = 24;
  localparam int CELL_W        = 32;

  // hash mixer constants
  localparam logic [31:0] MIX_C1 = 32'h7feb352d;
  localparam logic [31:0] MIX_C2 = 32'h846ca68b;
  localparam logic [31:0] HASH_X = 32'h9e3779b9;
  localparam logic [31:0] HASH_Y = 32'h85ebca6b;
  localparam logic [31:0] HASH_Z = 32'hc2b2ae35;

  // register map index (byte address bit 2)
  localparam logic REG_NOISE_SEED = 1'b0;

  // enables for a two-stage unit
  typedef struct packed {
    logic a;
    logic b;
  } stg_en_t;

endpackage

/* src/lvn3_mix.sv */
// One round of the 32-bit xorshift-multiply mixer, two register stages.
// Depends on lvn3_pkg.
module lvn3_mix
  import lvn3_pkg::*;
(
  input  logic        clk,
  input  stg_en_t     en,
  input  logic [31:0] v_in,
  output logic [31:0] h_out
);

  logic [31:0] v1_r, v2_r;
  logic [31:0] v1_nxt, v2_nxt;

  // shift-xor and multiply for both register stages
  always_comb begin
    v1_nxt = (v_in ^ (v_in >> 16)) * MIX_C1;
    v2_nxt = (v1_r ^ (v1_r >> 15)) * MIX_C2;
  end

  always_ff @(posedge clk) begin
    if (en.a) v1_r <= v1_nxt;
    if (en.b) v2_r <= v2_nxt;
  end

  // final shift-xor is folded into the consumer's stage
  assign h_out = v2_r ^ (v2_r >> 16);

endmodule

/* src/lvn3_lerp.sv */
// Linear blend of two 24-bit values by a 24-bit weight, two register stages.
// a*(1-s)+b*s is computed as a + ((b-a)*s >>> 24). Depends on lvn3_pkg.
module lvn3_lerp
  import lvn3_pkg::*;
(
  input  logic             clk,
  input  stg_en_t          en,
  input  logic [VAL_W-1:0] a_in,
  input  logic [VAL_W-1:0] b_in,
  input  logic [VAL_W-1:0] s_in,
  output logic [VAL_W-1:0] y_out
);

  logic signed [VAL_W:0]     diff;
  logic signed [VAL_W:0]     wgt;
  logic signed [2*VAL_W+1:0] prod_nxt, prod_r;
  logic [VAL_W-1:0]          a_r, y_r;
  logic [VAL_W+1:0]          sum;

  // signed difference times weight
  always_comb begin
    diff     = $signed({1'b0, b_in}) - $signed({1'b0, a_in});
    wgt      = $signed({1'b0, s_in});
    prod_nxt = diff * wgt;
  end

  // base plus floored correction; result always fits 24 bits
  assign sum = {2'b00, a_r} + prod_r[2*VAL_W+1:VAL_W];

  always_ff @(posedge clk) begin
    if (en.a) begin
      prod_r <= prod_nxt;
      a_r    <= a_in;
    end
    if (en.b) y_r <= sum[VAL_W-1:0];
  end

  assign y_out = y_r;

endmodule

/* src/lattice_value_noise_3d_core.sv */
// 3D lattice value noise, 16-stage pipeline; out_valid is the valid bit of stage 15.
// One word per cycle unless stalled; set by the per-stage multipliers of hash and blends.
// A stalled output holds its word; upstream stages keep filling empty slots, so in_stall
// rises only once every stage holds a word.
// Reset (synchronous, rst_n low) clears all stage valid bits and sets the seed to 0.
// Depends on lvn3_pkg, lvn3_mix, lvn3_lerp and lattice_value_noise_3d_core_assert.svh.
`include "lattice_value_noise_3d_core_assert.svh"

module lattice_value_noise_3d_core
  import lvn3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CELL_W-1:0] in_coord_x,
  input  logic signed [CELL_W-1:0] in_coord_y,
  input  logic signed [CELL_W-1:0] in_coord_z,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VAL_W-1:0]        out_noise_value,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int NS = 16;
  localparam logic [25:0] K3 = 26'd50331648;  // 3.0 in Q2.24

  // ---------------- configuration ----------------
  logic [31:0] seed_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NOISE_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NOISE_SEED) begin
      seed_r <= pwdata;
    end
  end

  // ---------------- valid chain ----------------
  // a stage loads when it is empty or its successor loads
  logic [NS-1:0] vld_r, vld_nxt, en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = (en & {vld_r[NS-2:0], in_valid}) | (~en & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

  // ---------------- stage 0: split into cell and fraction ----------------
  logic signed [CELL_W-1:0] coord [3];
  logic [CELL_W-1:0]        cell0_r [3][2];
  logic [VAL_W-1:0]         f0_r [3];

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        cell0_r[a][0] <= CELL_W'(coord[a] >>> FRAC_BITS);
        cell0_r[a][1] <= CELL_W'(coord[a] >>> FRAC_BITS) + CELL_W'(1);
        f0_r[a]       <= VAL_W'(coord[a][FRAC_BITS-1:0]) << (VAL_W - FRAC_BITS);
      end
    end
  end

  // ---------------- smoothstep: stages 1 and 2 ----------------
  logic [2*VAL_W-1:0] ff [3];
  logic [VAL_W-1:0]   q_r [3];
  logic [25:0]        k_r [3];
  logic [49:0]        qk [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ff[a] = {{VAL_W{1'b0}}, f0_r[a]} * {{VAL_W{1'b0}}, f0_r[a]};
      qk[a] = {26'd0, q_r[a]} * {24'd0, k_r[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        q_r[a] <= ff[a][2*VAL_W-1:VAL_W];
        k_r[a] <= K3 - {1'b0, f0_r[a], 1'b0};
      end
    end
  end

  // eased weights ride along until their blend stage
  logic [VAL_W-1:0] tx_r [2:9];
  logic [VAL_W-1:0] ty_r [2:11];
  logic [VAL_W-1:0] tz_r [2:13];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tx_r[2] <= qk[0][47:24];
      ty_r[2] <= qk[1][47:24];
      tz_r[2] <= qk[2][47:24];
    end
    for (int k = 3; k <= 9; k++) begin
      if (en[k]) tx_r[k] <= tx_r[k-1];
    end
    for (int k = 3; k <= 11; k++) begin
      if (en[k]) ty_r[k] <= ty_r[k-1];
    end
    for (int k = 3; k <= 13; k++) begin
      if (en[k]) tz_r[k] <= tz_r[k-1];
    end
  end

  // ---------------- y and z lattice terms ----------------
  logic [CELL_W-1:0] cy1_r [2];
  logic [CELL_W-1:0] yk_r [2];
  logic [CELL_W-1:0] cz_r [1:3][2];
  logic [CELL_W-1:0] zk_r [2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (en[1]) begin
        cy1_r[i]   <= cell0_r[1][i];
        cz_r[1][i] <= cell0_r[2][i];
      end
      if (en[2]) begin
        yk_r[i]    <= cy1_r[i] * HASH_Y;
        cz_r[2][i] <= cz_r[1][i];
      end
      if (en[3]) cz_r[3][i] <= cz_r[2][i];
      if (en[4]) zk_r[i] <= cz_r[3][i] * HASH_Z;
    end
  end

  // ---------------- corner hash: four mixer rounds, stages 1 to 8 ----------------
  logic [31:0] ha [2];
  logic [31:0] hb [4];
  logic [31:0] hc [8];
  logic [31:0] hd [8];

  // x round, one per x corner
  for (genvar i = 0; i < 2; i++) begin : g_rnd_x
    lvn3_mix u_mix (
      .clk   (clk),
      .en    ('{a: en[1], b: en[2]}),
      .v_in  (cell0_r[0][i] ^ HASH_X),
      .h_out (ha[i])
    );
  end

  // y round, index dy*2+dx
  for (genvar b = 0; b < 4; b++) begin : g_rnd_y
    lvn3_mix u_mix (
      .clk   (clk),
      .en    ('{a: en[3], b: en[4]}),
      .v_in  (ha[b % 2] ^ yk_r[b / 2]),
      .h_out (hb[b])
    );
  end

  // z round, index dz*4+dy*2+dx
  for (genvar c = 0; c < 8; c++) begin : g_rnd_z
    lvn3_mix u_mix (
      .clk   (clk),
      .en    ('{a: en[5], b: en[6]}),
      .v_in  (hb[c % 4] ^ zk_r[c / 4]),
      .h_out (hc[c])
    );
  end

  // seed round
  for (genvar c = 0; c < 8; c++) begin : g_rnd_s
    lvn3_mix u_mix (
      .clk   (clk),
      .en    ('{a: en[7], b: en[8]}),
      .v_in  (hc[c] ^ seed_r),
      .h_out (hd[c])
    );
  end

  // stage 9: corner values, low 24 bits
  logic [VAL_W-1:0] corner_r [8];

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int c = 0; c < 8; c++) begin
        corner_r[c] <= hd[c][VAL_W-1:0];
      end
    end
  end

  // ---------------- trilinear blend: stages 10 to 15 ----------------
  logic [VAL_W-1:0] lx [4];
  logic [VAL_W-1:0] ly [2];

  // along x, index dz*2+dy
  for (genvar m = 0; m < 4; m++) begin : g_blend_x
    lvn3_lerp u_lerp (
      .clk   (clk),
      .en    ('{a: en[10], b: en[11]}),
      .a_in  (corner_r[2*m]),
      .b_in  (corner_r[2*m+1]),
      .s_in  (tx_r[9]),
      .y_out (lx[m])
    );
  end

  // along y, index dz
  for (genvar d = 0; d < 2; d++) begin : g_blend_y
    lvn3_lerp u_lerp (
      .clk   (clk),
      .en    ('{a: en[12], b: en[13]}),
      .a_in  (lx[2*d]),
      .b_in  (lx[2*d+1]),
      .s_in  (ty_r[11]),
      .y_out (ly[d])
    );
  end

  // along z; its second register is the output register
  lvn3_lerp u_blend_z (
    .clk   (clk),
    .en    ('{a: en[14], b: en[15]}),
    .a_in  (ly[0]),
    .b_in  (ly[1]),
    .s_in  (tz_r[13]),
    .y_out (out_noise_value)
  );

  // ---------------- checks ----------------
  // input backs up only when every slot is occupied
  `LVN3_ASSERT_IMPL(a_stall_full, in_stall, &vld_r, "in_stall while a stage is empty")
  // an accepted word lands in stage 0
  `LVN3_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, vld_r[0], "accepted word lost")
  // a word blocked downstream stays put
  `LVN3_ASSERT_NEXT(a_hold_word, vld_r[0] && !en[1], vld_r[0], "blocked word dropped")

endmodule

/* tb/lattice_value_noise_3d_core_tb.sv */
// Testbench for lattice_value_noise_3d_core: directed table plus shaped random coordinates,
// every word checked against a local value-noise predictor. Needs lvn3_pkg and the core RTL.
`timescale 1ns / 100ps

module lattice_value_noise_3d_core_tb;
  import lvn3_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int NOISE_FRAC     = FRAC_BITS_DEF;
  localparam int PIPE_LATENCY   = 16;
  localparam int LONG_HOLD      = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;
  localparam int SEED_PHASES    = 8;
  localparam int PHASE_WORDS    = 192;
  localparam int PRESSURE_PHASE = 2;
  localparam int DIR_N          = 20;

  localparam logic [63:0]       ONE_Q24    = 64'd1 << 24;
  localparam logic [CELL_W-1:0] FRAC_MASK  = (32'd1 << NOISE_FRAC) - 32'd1;
  localparam logic [2:0]        SEED_ADDR  = {REG_NOISE_SEED, 2'b00};
  localparam logic [2:0]        UNMAPPED_ADDR = {~REG_NOISE_SEED, 2'b00};

  typedef struct packed {
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic [CELL_W-1:0] z;
  } coord_t;

  typedef struct packed {
    coord_t           where;
    logic [VAL_W-1:0] noise;
  } noise_exp_t;

  typedef enum int {CK_RANDOM, CK_WRAP, CK_FRAC_EDGE, CK_NEAR_ZERO, CK_PLANE, CK_NEIGHBOR}
    coord_kind_t;
  typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_t;

  // directed coordinates: zero, fraction extremes, lattice wrap, sign extremes, bit patterns.
  // None of these results is obvious by hand, so every row goes through the predictor.
  localparam coord_t DIR_COORDS [0:DIR_N-1] = '{
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00008000, 32'h00008000, 32'h00008000},
    {32'h0000ffff, 32'h0000ffff, 32'h0000ffff},
    {32'h00010000, 32'h00010000, 32'h00010000},
    {32'hffffffff, 32'hffffffff, 32'hffffffff},
    {32'hffff0000, 32'hffff0000, 32'hffff0000},
    {32'h80000000, 32'h80000000, 32'h80000000},
    {32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
    {32'h7fff0000, 32'h7fff0000, 32'h7fff0000},
    {32'h80000001, 32'h80000001, 32'h80000001},
    {32'h7fffffff, 32'h80000000, 32'h00000000},
    {32'hffff8000, 32'h00018000, 32'hfffe4000},
    {32'h00000000, 32'h00000000, 32'h00034567},
    {32'h12345678, 32'h00000000, 32'h9abcdef0},
    {32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa},
    {32'h55555555, 32'haaaaaaaa, 32'h55555555},
    {32'h00000001, 32'h0000fffe, 32'h00000100},
    {32'h00000000, 32'h7fffffff, 32'h80000000},
    {32'h80000000, 32'hffffffff, 32'h7fffffff},
    {32'h00010001, 32'h00010001, 32'h00010001}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CELL_W-1:0] in_coord_x = '0;
  logic [CELL_W-1:0] in_coord_y = '0;
  logic [CELL_W-1:0] in_coord_z = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] out_noise_value;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  noise_exp_t  pending_noise[$];
  logic [31:0] seed_shadow = '0;
  int          err_count = 0;
  int          hold_req = 0;
  int          burst_left = 0;

  lattice_value_noise_3d_core #(.FRAC_BITS(NOISE_FRAC)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_noise_value(out_noise_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // xorshift-multiply round
  function automatic logic [31:0] scramble(input logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * MIX_C1;
    v = v ^ (v >> 15);
    v = v * MIX_C2;
    return v ^ (v >> 16);
  endfunction

  function automatic logic [VAL_W-1:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
                                                    input logic [31:0] cz, input logic [31:0] seed);
    logic [31:0] h;
    h = scramble(cx ^ HASH_X);
    h = scramble(h ^ (cy * HASH_Y));
    h = scramble(h ^ (cz * HASH_Z));
    h = scramble(h ^ seed);
    return h[VAL_W-1:0];
  endfunction

  // smoothstep weight in Q0.24
  function automatic logic [31:0] smooth_weight(input logic [NOISE_FRAC-1:0] frac);
    logic [63:0] f, q, k, s;
    f = 64'(frac) << (24 - NOISE_FRAC);
    q = (f * f) >> 24;
    k = 64'd3 * ONE_Q24 - 64'd2 * f;
    s = (q * k) >> 24;
    return s[31:0];
  endfunction

  function automatic logic [VAL_W-1:0] mix_values(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b,
                                                  input logic [31:0] w);
    logic [63:0] r;
    r = 64'(a) * (ONE_Q24 - 64'(w)) + 64'(b) * 64'(w);
    return r[24 +: VAL_W];
  endfunction

  function automatic logic [VAL_W-1:0] predict_noise(input coord_t c, input logic [31:0] seed);
    logic [31:0]      x0, y0, z0, zc, wx, wy, wz;
    logic [VAL_W-1:0] lower, upper;
    logic [VAL_W-1:0] layer [2];
    // floor by arithmetic shift; the fraction is the low bits
    x0 = $signed(c.x) >>> NOISE_FRAC;
    y0 = $signed(c.y) >>> NOISE_FRAC;
    z0 = $signed(c.z) >>> NOISE_FRAC;
    wx = smooth_weight(c.x[NOISE_FRAC-1:0]);
    wy = smooth_weight(c.y[NOISE_FRAC-1:0]);
    wz = smooth_weight(c.z[NOISE_FRAC-1:0]);
    for (int dz = 0; dz < 2; dz++) begin
      zc = z0 + 32'(dz);
      lower = mix_values(lattice_hash(x0, y0, zc, seed), lattice_hash(x0 + 1, y0, zc, seed), wx);
      upper = mix_values(lattice_hash(x0, y0 + 1, zc, seed),
                         lattice_hash(x0 + 1, y0 + 1, zc, seed), wx);
      layer[dz] = mix_values(lower, upper, wy);
    end
    return mix_values(layer[0], layer[1], wz);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [31:0] shape_axis(input coord_kind_t kind, input logic [31:0] raw,
                                             input logic [31:0] prev_v);
    logic [31:0] edge_v;
    case (kind)
      CK_WRAP: begin
        // integer part at the signed and unsigned wrap points
        case ($urandom_range(0, 3))
          0: edge_v = 32'h00000000;
          1: edge_v = 32'hffffffff;
          2: edge_v = 32'h7fffffff;
          default: edge_v = 32'h80000000;
        endcase
        return (edge_v & ~FRAC_MASK) | (raw & FRAC_MASK);
      end
      CK_FRAC_EDGE: begin
        case ($urandom_range(0, 4))
          0: edge_v = 32'd0;
          1: edge_v = 32'd1;
          2: edge_v = 32'd1 << (NOISE_FRAC - 1);
          3: edge_v = FRAC_MASK - 32'd1;
          default: edge_v = FRAC_MASK;
        endcase
        return (raw & ~FRAC_MASK) | edge_v;
      end
      CK_NEAR_ZERO: return 32'($urandom_range(0, 4 << NOISE_FRAC)) - 32'(2 << NOISE_FRAC);
      CK_NEIGHBOR: return prev_v + 32'($urandom_range(0, 2 << NOISE_FRAC)) - 32'(1 << NOISE_FRAC);
      default: return raw;
    endcase
  endfunction

  function automatic coord_t random_coord(input coord_t prev);
    coord_t      c;
    coord_kind_t kind;
    int          r;
    r = $urandom_range(0, 9);
    kind = (r < 5) ? CK_RANDOM : coord_kind_t'(r - 4);
    c.x = shape_axis(kind, $urandom(), prev.x);
    c.y = shape_axis(kind, $urandom(), prev.y);
    c.z = shape_axis(kind, $urandom(), prev.z);
    // 2D slice
    if (kind == CK_PLANE) c.y = '0;
    return c;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input coord_t c);
    noise_exp_t e;
    int         gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid   <= 1'b1;
    in_coord_x <= c.x;
    in_coord_y <= c.y;
    in_coord_z <= c.z;
    do @(posedge clk); while (in_stall !== 1'b0);
    e.where = c;
    e.noise = predict_noise(c, seed_shadow);
    pending_noise.push_back(e);
    burst_left--;
    @(negedge clk);
  endtask

  // register access with a setup and an access phase, entered and left at a falling edge
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_seed_readback();
    logic [31:0] rd;
    apb_xfer(1'b0, SEED_ADDR, '0, rd);
    if (rd !== seed_shadow)
      flag_error($sformatf("seed readback expected %h got %h", seed_shadow, rd));
  endtask

  // drop valid, let the pipeline empty, then let it settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_noise.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    logic [31:0] rd;
    logic [31:0] seed;
    coord_t      prev;
    prev = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_seed_readback();

    // directed table with the reset seed
    for (int i = 0; i < DIR_N; i++) send_word(DIR_COORDS[i]);
    drain_pipe();

    // a write past the register map must leave the seed alone
    apb_xfer(1'b1, UNMAPPED_ADDR, 32'hdeadbeef, rd);
    check_seed_readback();

    for (int p = 0; p < SEED_PHASES; p++) begin
      case (p)
        0: seed = 32'h7fffffff;
        1: seed = 32'h80000000;
        2: seed = 32'hffffffff;
        3: seed = 32'h00000001;
        7: seed = 32'h00000000;
        default: seed = $urandom();
      endcase
      apb_xfer(1'b1, SEED_ADDR, seed, rd);
      seed_shadow = seed;
      check_seed_readback();
      // long receiver hold so the pipe fills and backs up into the input
      if (p == PRESSURE_PHASE) hold_req++;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        prev = random_coord(prev);
        send_word(prev);
      end
      drain_pipe();
    end

    if (err_count == 0 && pending_noise.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // stall pattern: modes of random length, plus one long hold on request
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    int         hold_seen;
    mode = SINK_FREE;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          SINK_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          SINK_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          SINK_TOGGLE: out_stall <= ~out_stall;
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // compare each taken word with the oldest prediction
  always @(posedge clk) begin : noise_monitor
    noise_exp_t head;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_noise.size() == 0) begin
        flag_error($sformatf("unexpected word noise=%h", out_noise_value));
      end else begin
        head = pending_noise.pop_front();
        if (out_noise_value !== head.noise)
          flag_error($sformatf("noise x=%h y=%h z=%h expected %h got %h", head.where.x,
                               head.where.y, head.where.z, head.noise, out_noise_value));
      end
    end
  end

  // hang detector: cycles with no word moving on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
